@@ rtl/core/ctd_pkg.sv @@
// shared types and constants of the chunked transfer decoder
package ctd_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_TERMINAL = 2'd1;
    localparam logic [1:0] EV_INVALID  = 2'd2;

    // one classified input beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_hex;
        logic [3:0] hex_val;
    } ctd_beat_t;

endpackage

@@ rtl/core/ctd_front.sv @@
// front end: takes input beats and classifies each byte for the parser
module ctd_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_read_end,
    output logic                q_wr_en,
    output ctd_pkg::ctd_beat_t  q_wr_beat,
    input  logic                q_full
);
    import ctd_pkg::*;

    logic is_dec;
    logic is_lower;
    logic is_upper;

    assign s_ready = !q_full;
    assign q_wr_en = s_valid && !q_full;

    always_comb begin
        is_dec   = (s_data_byte >= 8'h30) && (s_data_byte <= 8'h39);
        is_lower = (s_data_byte >= 8'h61) && (s_data_byte <= 8'h66);
        is_upper = (s_data_byte >= 8'h41) && (s_data_byte <= 8'h46);

        q_wr_beat.data     = s_data_byte;
        q_wr_beat.last     = s_read_end;
        q_wr_beat.is_cr    = (s_data_byte == CHAR_CR);
        q_wr_beat.is_lf    = (s_data_byte == CHAR_LF);
        // tab, lf, vt, ff, cr and space
        q_wr_beat.is_space = ((s_data_byte >= 8'h09) && (s_data_byte <= 8'h0d))
                             || (s_data_byte == 8'h20);
        q_wr_beat.is_hex   = is_dec || is_lower || is_upper;
        if (is_dec) begin
            q_wr_beat.hex_val = s_data_byte[3:0];
        end else if (is_lower || is_upper) begin
            // a-f and A-F share the low three bits: 1..6 maps to 10..15
            q_wr_beat.hex_val = 4'(s_data_byte[2:0] + 3'd1) + 4'd8;
        end else begin
            q_wr_beat.hex_val = 4'd0;
        end
    end

endmodule

@@ rtl/core/ctd_queue.sv @@
// two-entry queue of classified beats between front and back
module ctd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  ctd_pkg::ctd_beat_t  wr_beat,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output ctd_pkg::ctd_beat_t  rd_beat
);
    import ctd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctd_beat_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_beat  = entry_reg[rd_ptr_reg];

    always_comb begin
        do_wr       = wr_en && !full;
        do_rd       = rd_en && rd_valid;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_beat;
        end
    end

endmodule

@@ rtl/core/ctd_back.sv @@
// back end: size line parser, payload forwarding and output register
module ctd_back #(
    parameter int SIZE_BITS = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  ctd_pkg::ctd_beat_t  q_beat,
    output logic                q_rd_en,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic [1:0]          m_event_res
);
    import ctd_pkg::*;

    typedef enum logic [3:0] {
        MODE_SIZE  = 4'b0001,
        MODE_DATA  = 4'b0010,
        MODE_TRAIL = 4'b0100,
        MODE_DROP  = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'b001,
        PH_DIGIT = 3'b010,
        PH_TAIL  = 3'b100
    } phase_t;

    mode_t                  mode_reg, mode_next;
    phase_t                 phase_reg, phase_next;
    logic [SIZE_BITS-1:0]   size_reg, size_next;
    logic [SIZE_BITS-1:0]   left_reg, left_next;
    logic                   bad_reg, bad_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [1:0]             out_event_reg, out_event_next;

    logic                   pop;
    phase_t                 eff_phase;
    logic [SIZE_BITS-1:0]   eff_size;
    logic                   eff_bad;
    phase_t                 ph1;

    assign pop         = q_valid && (!out_valid_reg || m_ready);
    assign q_rd_en     = pop;
    assign m_valid     = out_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_event_res = out_event_reg;

    always_comb begin
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        size_next      = size_reg;
        left_next      = left_reg;
        bad_next       = bad_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_event_next = out_event_reg;

        // leaving the trailer starts from a fresh line
        eff_phase = (mode_reg == MODE_TRAIL) ? PH_LEAD : phase_reg;
        eff_size  = (mode_reg == MODE_TRAIL) ? '0 : size_reg;
        eff_bad   = (mode_reg == MODE_TRAIL) ? 1'b0 : bad_reg;
        // a held cr that did not start cr lf counts as whitespace
        ph1       = (pend_reg && eff_phase == PH_DIGIT) ? PH_TAIL : eff_phase;

        if (pop) begin
            case (mode_reg)
                MODE_DATA: begin
                    out_valid_next = 1'b1;
                    out_byte_next  = q_beat.data;
                    out_event_next = EV_PAYLOAD;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == SIZE_BITS'(1)) begin
                        mode_next = MODE_TRAIL;
                        pend_next = 1'b0;
                    end
                end
                MODE_DROP: begin
                    if (q_beat.last) begin
                        mode_next  = MODE_SIZE;
                        phase_next = PH_LEAD;
                        size_next  = '0;
                        bad_next   = 1'b0;
                        pend_next  = 1'b0;
                    end
                end
                MODE_SIZE, MODE_TRAIL: begin
                    if (mode_reg == MODE_TRAIL && !pend_reg && q_beat.is_cr) begin
                        pend_next = 1'b1;
                    end else if (pend_reg && q_beat.is_lf) begin
                        // end of line, or end of the cr lf after payload
                        phase_next = PH_LEAD;
                        size_next  = '0;
                        bad_next   = 1'b0;
                        pend_next  = 1'b0;
                        if (mode_reg == MODE_TRAIL) begin
                            mode_next = MODE_SIZE;
                        end else if (eff_bad || eff_phase == PH_LEAD) begin
                            mode_next      = q_beat.last ? MODE_SIZE : MODE_DROP;
                            out_valid_next = 1'b1;
                            out_byte_next  = 8'd0;
                            out_event_next = EV_INVALID;
                        end else if (eff_size == '0) begin
                            mode_next      = q_beat.last ? MODE_SIZE : MODE_DROP;
                            out_valid_next = 1'b1;
                            out_byte_next  = 8'd0;
                            out_event_next = EV_TERMINAL;
                        end else begin
                            mode_next = MODE_DATA;
                            left_next = eff_size;
                        end
                    end else begin
                        mode_next  = MODE_SIZE;
                        phase_next = ph1;
                        size_next  = eff_size;
                        bad_next   = eff_bad;
                        if (q_beat.is_cr) begin
                            pend_next = 1'b1;
                        end else begin
                            pend_next = 1'b0;
                            if (q_beat.is_space) begin
                                if (ph1 == PH_DIGIT) begin
                                    phase_next = PH_TAIL;
                                end
                            end else if (!q_beat.is_hex || ph1 == PH_TAIL) begin
                                bad_next = 1'b1;
                            end else begin
                                phase_next = PH_DIGIT;
                                if (!eff_bad) begin
                                    // shifting in a digit overflows if the top nibble is set
                                    if (eff_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                                        bad_next = 1'b1;
                                    end else begin
                                        size_next = {eff_size[SIZE_BITS-5:0], q_beat.hex_val};
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                    mode_next = MODE_SIZE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SIZE;
            phase_reg     <= PH_LEAD;
            size_reg      <= '0;
            left_reg      <= '0;
            bad_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            size_reg      <= size_next;
            left_reg      <= left_next;
            bad_reg       <= bad_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_event_reg <= out_event_next;
    end

endmodule

@@ rtl/core/chunked_transfer_decoder.sv @@
// chunked transfer decoder: one input byte per cycle, payload bytes and events out
// an accepted beat is written into the queue entry, then the parser result is registered in the output register
// throughput: one byte per cycle while the output is not stalled, set by the parser update in the back end
// a stalled output register fills the two-entry queue, and a full queue holds off input
// reset: synchronous active-low, parser returns to size line mode, queue and output empty
// no memory clearing pass is needed after reset
module chunked_transfer_decoder #(
    parameter int SIZE_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_read_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_event_res
);
    import ctd_pkg::*;

    logic       q_wr_en;
    ctd_beat_t  q_wr_beat;
    logic       q_full;
    logic       q_rd_en;
    logic       q_valid;
    ctd_beat_t  q_rd_beat;

    ctd_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_read_end  (s_read_end),
        .q_wr_en     (q_wr_en),
        .q_wr_beat   (q_wr_beat),
        .q_full      (q_full)
    );

    ctd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr_en),
        .wr_beat  (q_wr_beat),
        .full     (q_full),
        .rd_en    (q_rd_en),
        .rd_valid (q_valid),
        .rd_beat  (q_rd_beat)
    );

    ctd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_beat      (q_rd_beat),
        .q_rd_en     (q_rd_en),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_event_res (m_event_res)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the chunked transfer decoder
module tb_top;
    import ctd_pkg::*;

    localparam int SIZE_BITS   = 31;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [35:0] SIZE_MAX = (36'd1 << SIZE_BITS) - 36'd1;

    typedef enum logic [1:0] {MD_SIZE, MD_BODY, MD_TRAIL, MD_DISCARD} dec_mode_t;
    typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_TRAIL} line_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] ev;
    } dec_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_read_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_event_res;

    chunked_transfer_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_read_end  (s_read_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_event_res (m_event_res)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // decoder state as predicted from accepted beats
    dec_mode_t   dec_mode  = MD_SIZE;
    logic [31:0] dec_size  = '0;
    logic [30:0] dec_left  = '0;
    line_phase_t dec_phase = PH_LEAD;
    logic        dec_bad   = 1'b0;
    logic        dec_cr    = 1'b0;

    dec_result_t decoded_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          beats_sent = 0;
    int          burst_left = 0;
    int          stall_style = 0;
    int          stall_timer = 0;

    function automatic void clear_size_line();
        dec_size  = '0;
        dec_phase = PH_LEAD;
        dec_bad   = 1'b0;
        dec_cr    = 1'b0;
    endfunction

    function automatic void size_line_char(input logic [7:0] c);
        logic [4:0]  digit;
        logic [35:0] grown;
        digit = 5'h10;
        if (c >= "0" && c <= "9") digit = {1'b0, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) digit = {1'b0, c[3:0] + 4'd9};
        if ((c >= 8'd9 && c <= 8'd13) || c == 8'd32) begin
            if (dec_phase == PH_DIGITS) dec_phase = PH_TRAIL;
            return;
        end
        if (digit[4] || dec_phase == PH_TRAIL) begin
            dec_bad = 1'b1;
            return;
        end
        dec_phase = PH_DIGITS;
        if (dec_bad) return;
        grown = {dec_size, 4'h0} + {32'h0, digit[3:0]};
        if (grown > SIZE_MAX) dec_bad = 1'b1;
        else dec_size = grown[31:0];
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic last);
        logic [1:0] ev;
        case (dec_mode)
            MD_BODY: begin
                decoded_q.push_back('{data: c, ev: EV_PAYLOAD});
                dec_left = dec_left - 31'd1;
                if (dec_left == '0) begin
                    dec_mode = MD_TRAIL;
                    dec_cr   = 1'b0;
                end
                return;
            end
            MD_DISCARD: begin
                if (last) begin
                    dec_mode = MD_SIZE;
                    clear_size_line();
                end
                return;
            end
            MD_TRAIL: begin
                if (!dec_cr && c == CHAR_CR) begin
                    dec_cr = 1'b1;
                    return;
                end
                if (dec_cr && c == CHAR_LF) begin
                    dec_mode = MD_SIZE;
                    clear_size_line();
                    return;
                end
                // no proper trailer: this byte (and a held cr) start the next size line
                dec_mode  = MD_SIZE;
                dec_size  = '0;
                dec_phase = PH_LEAD;
                dec_bad   = 1'b0;
            end
            default: ;
        endcase
        if (dec_cr && c == CHAR_LF) begin
            if (dec_bad || dec_phase == PH_LEAD) begin
                ev = EV_INVALID;
            end else if (dec_size == '0) begin
                ev = EV_TERMINAL;
            end else begin
                ev = EV_PAYLOAD;
                dec_left = dec_size[30:0];
            end
            clear_size_line();
            if (ev == EV_PAYLOAD) begin
                dec_mode = MD_BODY;
                return;
            end
            dec_mode = last ? MD_SIZE : MD_DISCARD;
            decoded_q.push_back('{data: 8'h00, ev: ev});
            return;
        end
        if (dec_cr) size_line_char(CHAR_CR);
        if (c == CHAR_CR) begin
            dec_cr = 1'b1;
        end else begin
            dec_cr = 1'b0;
            size_line_char(c);
        end
    endfunction

    // result check first, then prediction of the beat taken at this edge
    always @(posedge aclk) begin
        dec_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result, actual byte %02h event %0d",
                             $time, m_out_byte, m_event_res);
                    error_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                 $time, want.data, m_out_byte);
                        error_count++;
                    end
                    if (m_event_res !== want.ev) begin
                        $display("%0t: event_res mismatch, expected %0d actual %0d",
                                 $time, want.ev, m_event_res);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) decode_byte(s_data_byte, s_read_end);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls in styles that are picked at random each time the stall timer runs out
    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_timer % 12 == 0);
        endcase
    end

    function automatic logic rand_last();
        return $urandom_range(0, 7) == 0;
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 4))
            0: return 8'd9;
            1: return 8'd10;
            2: return 8'd11;
            3: return 8'd12;
            default: return 8'd32;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid     = 1'b1;
        s_data_byte = b;
        s_read_end  = last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
    endtask

    // read_end only on the final character
    task automatic send_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], last && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
    endtask

    task automatic end_read();
        repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_plain_chunks();
        send_text("5\015\012", 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hff, 1'b1);
        send_beat(CHAR_CR, 1'b0);
        send_beat(CHAR_LF, 1'b0);
        send_beat(8'h55, 1'b0);
        send_text("\015\012aF\015\012", 1'b0);
        repeat (175) send_beat(8'($urandom_range(0, 255)), rand_last());
        send_text("\015\012B\015\012", 1'b0);
        repeat (11) send_beat(8'($urandom_range(0, 255)), 1'b0);
        // terminal report on the last beat of a read: nothing dropped
        send_text("\015\0120\015\012", 1'b1);
        send_text("1\015\012Q\015\012", 1'b0);
    endtask

    task automatic test_size_line_spacing();
        send_text("\t\013 \0143 \015\012abc\015\012", 1'b0);
        // lone lf before the digits, lone cr after them
        send_text("\0122\015 \015\012xy\015\012", 1'b0);
        send_text("0000000001\015\012z\015\012", 1'b0);
    endtask

    task automatic test_bad_lines();
        send_text("\015\012", 1'b0);
        end_read();
        send_text("   \015\012", 1'b0);
        end_read();
        send_text("1 2\015\012", 1'b0);
        end_read();
        send_text("+5\015\012", 1'b0);
        end_read();
        send_text("0x5\015\012", 1'b0);
        end_read();
        send_text("g\015\012", 1'b0);
        end_read();
        send_text("80000000\015\012", 1'b0);
        end_read();
        send_text("q\015\012", 1'b1);
        send_text("1\015\012R\015\012", 1'b0);
    endtask

    task automatic test_trailer_cases();
        send_text("1\015\012X2\015\012YY\015\012", 1'b0);
        // cr lf split across reads
        send_text("1\015\012Z", 1'b0);
        send_beat(CHAR_CR, 1'b1);
        send_beat(CHAR_LF, 1'b0);
        // cr then a digit: the cr is whitespace on the next size line
        send_text("1\015\012W\0151\015\012V\015\012", 1'b0);
        send_text("000\015\012", 1'b0);
        end_read();
    endtask

    task automatic test_random_stream();
        int          stop_at;
        int          pick;
        int          size;
        string       hs;
        logic [7:0]  c;
        stop_at = beats_sent + 150;
        while (beats_sent < stop_at) begin
            if (dec_mode == MD_DISCARD) end_read();
            if ($urandom_range(0, 29) == 0) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 24);
                hs = $sformatf("%0h", size);
                repeat ($urandom_range(0, 2)) send_beat(rand_space(), rand_last());
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
                    send_beat("0", rand_last());
                for (int i = 0; i < hs.len(); i++) begin
                    c = hs[i];
                    if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
                    send_beat(c, rand_last());
                end
                repeat ($urandom_range(0, 2)) send_beat(rand_space(), rand_last());
                send_beat(CHAR_CR, rand_last());
                send_beat(CHAR_LF, rand_last());
                repeat (size) send_beat(8'($urandom_range(0, 255)), rand_last());
                case ($urandom_range(0, 9))
                    0: ;
                    1: begin
                        send_beat(CHAR_CR, rand_last());
                        send_beat(8'($urandom_range(0, 255)), rand_last());
                    end
                    default: begin
                        send_beat(CHAR_CR, rand_last());
                        send_beat(CHAR_LF, rand_last());
                    end
                endcase
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 3)) send_beat("0", rand_last());
                if ($urandom_range(0, 1)) send_beat(rand_space(), rand_last());
                send_beat(CHAR_CR, rand_last());
                send_beat(CHAR_LF, rand_last());
            end else if (pick < 90) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: send_text($sformatf("%0h %0h", $urandom_range(1, 15), $urandom_range(0, 15)),
                                 rand_last());
                    2: begin
                        send_text($sformatf("%0h", $urandom_range(0, 255)), rand_last());
                        send_beat(8'($urandom_range(0, 255)), rand_last());
                    end
                    default: send_text($sformatf("%08h", $urandom | 32'h8000_0000), rand_last());
                endcase
                send_beat(CHAR_CR, rand_last());
                send_beat(CHAR_LF, rand_last());
            end else begin
                repeat ($urandom_range(1, 6)) send_beat(8'($urandom_range(0, 255)), rand_last());
            end
        end
    endtask

    // largest legal size: the decoder stays in payload for the rest of the run
    task automatic test_max_size();
        send_text("7FFFFFFF\015\012", 1'b0);
        repeat (20) send_beat(8'($urandom_range(0, 255)), rand_last());
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_plain_chunks();
        test_size_line_spacing();
        test_bad_lines();
        wait_drained();
        test_trailer_cases();
        test_random_stream();
        test_max_size();
        s_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
